[src/bpcc_pkg.sv]
package bpcc_pkg;

   // Field widths fixed by the register map and the result word
   localparam int CFG_W = 17;
   localparam int PAT_W = 10;

   // Defaults for the top-level parameters
   localparam int DEF_PATTERN_LENGTH = 10;
   localparam int DEF_COUNT_WIDTH    = 17;

   // Register values after reset
   localparam logic [CFG_W-1:0] MIN_SIZE_RESET    = 17'd2048;
   localparam logic [CFG_W-1:0] TARGET_SIZE_RESET = 17'd8192;
   localparam logic [CFG_W-1:0] MAX_SIZE_RESET    = 17'd65536;
   localparam logic [PAT_W-1:0] PATTERN_RESET     = 10'd618;

   // Register indexes
   typedef enum logic [1:0] {
      CSR_MIN_SIZE     = 2'd0,
      CSR_TARGET_SIZE  = 2'd1,
      CSR_MAX_SIZE     = 2'd2,
      CSR_PATTERN_BITS = 2'd3
   } bpcc_csr_index_type;

   // Where the cut came from
   typedef enum logic [1:0] {
      SRC_SHORT = 2'd0,
      SRC_NONE  = 2'd1,
      SRC_LEFT  = 2'd2,
      SRC_RIGHT = 2'd3
   } bpcc_source_type;

   // Configuration as seen by the datapath
   typedef struct packed {
      logic [CFG_W-1:0] min_size;
      logic [CFG_W-1:0] target_size;
      logic [CFG_W-1:0] max_size;
      logic [PAT_W-1:0] pattern_bits;
   } bpcc_cfg_type;

   // Scan stage view of the current byte, after its update
   typedef struct packed {
      logic             valid;
      logic             last;
      logic             left_found;
      logic [CFG_W-1:0] left_cut;
      logic             right_found;
      logic [CFG_W-1:0] right_cut;
   } bpcc_tally_type;

endpackage

[src/bpcc_if.sv]
interface bpcc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_last;

   modport source (output valid, output data_byte, output is_last, input ready);
   modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface bpcc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [bpcc_pkg::CFG_W-1:0]        cut_length;
   bpcc_pkg::bpcc_source_type         cut_source;

   modport source (output valid, output cut_length, output cut_source, input ready);
   modport sink   (input valid, input cut_length, input cut_source, output ready);
endinterface

interface bpcc_csr_if;
   logic                              valid;
   logic                              ready;
   bpcc_pkg::bpcc_csr_index_type      index;
   logic [bpcc_pkg::CFG_W-1:0]        data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[src/bit_pattern_chunk_cutter.sv]
// Content-defined chunk cutter: takes a buffer one byte per word, shifts the low bit
// of each byte into a PATTERN_LENGTH-bit window and compares it with pattern_bits,
// keeping the last match ending in [min_size + PATTERN_LENGTH, target_size] and the
// first in [target_size + PATTERN_LENGTH, max_size]; the word with is_last yields
// one cut_length and its cut_source. A byte is accepted every cycle while no last
// byte waits in the input register for the output slot; the last byte's result is
// formed by the scan stage's window compare and count update and registered in the
// output register. While a result waits to be taken, non-final bytes of the next
// buffer keep flowing; a second last byte waits in the input register. The user
// must write registers only with no buffer in flight; the block does not enforce it.
module bit_pattern_chunk_cutter #(
   parameter int PATTERN_LENGTH = bpcc_pkg::DEF_PATTERN_LENGTH,
   parameter int COUNT_WIDTH    = bpcc_pkg::DEF_COUNT_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   bpcc_req_if.sink    req_ch,
   bpcc_rsp_if.source  rsp_ch,
   bpcc_csr_if.sink    csr_ch
);

   bpcc_pkg::bpcc_cfg_type   cfg;
   bpcc_pkg::bpcc_tally_type tally;
   logic [COUNT_WIDTH-1:0]   count;
   logic                     out_free;

   bpcc_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   bpcc_scan #(
      .PATTERN_LENGTH (PATTERN_LENGTH),
      .COUNT_WIDTH    (COUNT_WIDTH)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .cfg      (cfg),
      .out_free (out_free),
      .tally    (tally),
      .count    (count)
   );

   bpcc_select #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_select (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .tally    (tally),
      .count    (count),
      .out_free (out_free),
      .rsp_ch   (rsp_ch)
   );

endmodule

[src/bpcc_csr.sv]
module bpcc_csr (
   input  logic                 clock,
   input  logic                 reset,
   bpcc_csr_if.sink             csr_ch,
   output bpcc_pkg::bpcc_cfg_type cfg
);

   bpcc_pkg::bpcc_cfg_type cfg_ff;
   bpcc_pkg::bpcc_cfg_type cfg_in;

   // Writes are always taken
   assign csr_ch.ready = 1'b1;

   // Decode the write word into one register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            bpcc_pkg::CSR_MIN_SIZE:     cfg_in.min_size     = csr_ch.data;
            bpcc_pkg::CSR_TARGET_SIZE:  cfg_in.target_size  = csr_ch.data;
            bpcc_pkg::CSR_MAX_SIZE:     cfg_in.max_size     = csr_ch.data;
            bpcc_pkg::CSR_PATTERN_BITS: cfg_in.pattern_bits =
               csr_ch.data[bpcc_pkg::PAT_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_size     <= bpcc_pkg::MIN_SIZE_RESET;
         cfg_ff.target_size  <= bpcc_pkg::TARGET_SIZE_RESET;
         cfg_ff.max_size     <= bpcc_pkg::MAX_SIZE_RESET;
         cfg_ff.pattern_bits <= bpcc_pkg::PATTERN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/bpcc_scan.sv]
module bpcc_scan #(
   parameter int PATTERN_LENGTH = bpcc_pkg::DEF_PATTERN_LENGTH,
   parameter int COUNT_WIDTH    = bpcc_pkg::DEF_COUNT_WIDTH
) (
   input  logic                     clock,
   input  logic                     reset,
   bpcc_req_if.sink                 req_ch,
   input  bpcc_pkg::bpcc_cfg_type   cfg,
   input  logic                     out_free,
   output bpcc_pkg::bpcc_tally_type tally,
   output logic [COUNT_WIDTH-1:0]   count
);

   localparam int CFG_W = bpcc_pkg::CFG_W;
   localparam int CMP_W = (COUNT_WIDTH > CFG_W ? COUNT_WIDTH : CFG_W) + 1;
   localparam int PEXT_W = PATTERN_LENGTH > bpcc_pkg::PAT_W ?
                           PATTERN_LENGTH : bpcc_pkg::PAT_W;

   // Input register
   logic s1_valid_ff, s1_valid_in;
   logic s1_bit_ff;
   logic s1_last_ff;

   // Buffer state
   logic [COUNT_WIDTH-1:0]    pos_ff, pos_in;
   logic [PATTERN_LENGTH-1:0] hist_ff, hist_in;
   logic [CFG_W-1:0]          left_cut_ff, left_cut_in;
   logic                      left_found_ff, left_found_in;
   logic [CFG_W-1:0]          right_cut_ff, right_cut_in;
   logic                      right_found_ff, right_found_in;

   logic                      advance;
   logic                      saturated;
   logic [COUNT_WIDTH-1:0]    pos_next;
   logic [PATTERN_LENGTH-1:0] hist_next;
   logic [PEXT_W-1:0]         pattern_ext;
   logic                      match;
   logic [CMP_W-1:0]          end_w;
   logic                      left_hit;
   logic                      right_hit;

   // A byte without a result always moves on; a last byte waits for the output slot
   assign advance      = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_ch.ready = !s1_valid_ff || advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_ch.ready) begin
         s1_valid_in = req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Payload of the input register
   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         s1_bit_ff  <= req_ch.data_byte[0];
         s1_last_ff <= req_ch.is_last;
      end
   end

   // Shift the low bit in and test the window against both regions
   assign saturated   = &pos_ff;
   assign pos_next    = pos_ff + COUNT_WIDTH'(1);
   assign hist_next   = (hist_ff >> 1) |
                        (PATTERN_LENGTH'(s1_bit_ff) << (PATTERN_LENGTH - 1));
   assign pattern_ext = PEXT_W'(cfg.pattern_bits);
   assign match       = hist_next == pattern_ext[PATTERN_LENGTH-1:0];
   assign end_w       = CMP_W'(pos_next);

   assign left_hit  = match &&
                      end_w >= CMP_W'(cfg.min_size) + CMP_W'(PATTERN_LENGTH) &&
                      end_w <= CMP_W'(cfg.target_size);
   assign right_hit = match && !right_found_ff &&
                      end_w >= CMP_W'(cfg.target_size) + CMP_W'(PATTERN_LENGTH) &&
                      end_w <= CMP_W'(cfg.max_size);

   always_comb begin
      pos_in         = pos_ff;
      hist_in        = hist_ff;
      left_cut_in    = left_cut_ff;
      left_found_in  = left_found_ff;
      right_cut_in   = right_cut_ff;
      right_found_in = right_found_ff;
      if (!saturated) begin
         pos_in  = pos_next;
         hist_in = hist_next;
         if (left_hit) begin
            left_cut_in   = CFG_W'(pos_next);
            left_found_in = 1'b1;
         end
         if (right_hit) begin
            right_cut_in   = CFG_W'(pos_next);
            right_found_in = 1'b1;
         end
      end
   end

   // Hand the updated view to the selector
   always_comb begin
      tally.valid       = s1_valid_ff;
      tally.last        = s1_last_ff;
      tally.left_found  = left_found_in;
      tally.left_cut    = left_cut_in;
      tally.right_found = right_found_in;
      tally.right_cut   = right_cut_in;
      count             = pos_in;
   end

   // Commit the byte; drop all buffer state after the last one
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         hist_ff        <= '0;
         left_cut_ff    <= '0;
         left_found_ff  <= 1'b0;
         right_cut_ff   <= '0;
         right_found_ff <= 1'b0;
      end else if (advance) begin
         if (s1_last_ff) begin
            pos_ff         <= '0;
            hist_ff        <= '0;
            left_cut_ff    <= '0;
            left_found_ff  <= 1'b0;
            right_cut_ff   <= '0;
            right_found_ff <= 1'b0;
         end else begin
            pos_ff         <= pos_in;
            hist_ff        <= hist_in;
            left_cut_ff    <= left_cut_in;
            left_found_ff  <= left_found_in;
            right_cut_ff   <= right_cut_in;
            right_found_ff <= right_found_in;
         end
      end
   end

endmodule

[src/bpcc_select.sv]
module bpcc_select #(
   parameter int COUNT_WIDTH = bpcc_pkg::DEF_COUNT_WIDTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  bpcc_pkg::bpcc_cfg_type   cfg,
   input  bpcc_pkg::bpcc_tally_type tally,
   input  logic [COUNT_WIDTH-1:0]   count,
   output logic                     out_free,
   bpcc_rsp_if.source               rsp_ch
);

   localparam int CFG_W = bpcc_pkg::CFG_W;
   localparam int CMP_W = (COUNT_WIDTH > CFG_W ? COUNT_WIDTH : CFG_W) + 1;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CFG_W-1:0]          cut_length_ff, cut_length_in;
   bpcc_pkg::bpcc_source_type cut_source_ff, cut_source_in;

   logic             load;
   logic [CMP_W-1:0] count_w;
   logic [CFG_W-1:0] left_gap;
   logic [CFG_W-1:0] right_gap;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign load     = tally.valid && tally.last && out_free;

   assign count_w   = CMP_W'(count);
   assign left_gap  = cfg.target_size - tally.left_cut;
   assign right_gap = tally.right_cut - cfg.target_size;

   // Pick the cut: short buffer, then nearest match to target_size, else the fallback
   always_comb begin
      if (count_w <= CMP_W'(cfg.min_size)) begin
         cut_length_in = CFG_W'(count);
         cut_source_in = bpcc_pkg::SRC_SHORT;
      end else if (tally.left_found &&
                   (!tally.right_found || left_gap <= right_gap)) begin
         cut_length_in = tally.left_cut;
         cut_source_in = bpcc_pkg::SRC_LEFT;
      end else if (tally.right_found) begin
         cut_length_in = tally.right_cut;
         cut_source_in = bpcc_pkg::SRC_RIGHT;
      end else begin
         cut_length_in = (count_w < CMP_W'(cfg.target_size)) ?
                         CFG_W'(count) : cfg.target_size;
         cut_source_in = bpcc_pkg::SRC_NONE;
      end
   end

   // Output register: hold until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cut_length_ff <= cut_length_in;
         cut_source_ff <= cut_source_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.cut_length = cut_length_ff;
   assign rsp_ch.cut_source = cut_source_ff;

endmodule

[src/bpcc_checker.sv]
module bpcc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       req_is_last,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [bpcc_pkg::CFG_W-1:0] rsp_cut_length,
   input logic [1:0]                 rsp_cut_source
);

   // No result word right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present right after reset");

   // Input only stalls behind a waiting result
   a_ready_when_out_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output register");

   // A non-final byte never blocks the next word
   a_mid_byte_no_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_is_last |=> req_ready)
      else $error("input stalled after a non-final byte");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_cut_length) && $stable(rsp_cut_source))
      else $error("result word changed while stalled");

endmodule

bind bit_pattern_chunk_cutter bpcc_checker u_bpcc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .req_is_last    (req_ch.is_last),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_cut_length (rsp_ch.cut_length),
   .rsp_cut_source (rsp_ch.cut_source)
);
